>>> design/rvx_pkg.sv
// Package with the decoded-item and result types and the operation codes of the execute core.
`default_nettype none
package rvx_pkg;

   localparam int QDEPTH = 2;

   localparam logic [31:0] IO_MASK   = 32'hc000_0000;
   localparam logic [31:0] WORD_MASK = 32'hffff_fffc;
   localparam logic [31:0] UPPER_MASK = 32'hffff_f000;

   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_LOAD   = 7'h03;

   localparam logic [4:0] OP_PRELOAD = 5'd0;
   localparam logic [4:0] OP_ILLEGAL = 5'd1;
   localparam logic [4:0] OP_LUI     = 5'd2;
   localparam logic [4:0] OP_AUIPC   = 5'd3;
   localparam logic [4:0] OP_ADDI    = 5'd4;
   localparam logic [4:0] OP_ANDI    = 5'd5;
   localparam logic [4:0] OP_XOR     = 5'd6;
   localparam logic [4:0] OP_ADD     = 5'd7;
   localparam logic [4:0] OP_SUB     = 5'd8;
   localparam logic [4:0] OP_LW      = 5'd9;
   localparam logic [4:0] OP_LBU     = 5'd10;
   localparam logic [4:0] OP_SW      = 5'd11;
   localparam logic [4:0] OP_BR      = 5'd12;
   localparam logic [4:0] OP_JAL     = 5'd13;
   localparam logic [4:0] OP_JR      = 5'd14;

   localparam logic [2:0] BR_EQ  = 3'd0;
   localparam logic [2:0] BR_NE  = 3'd1;
   localparam logic [2:0] BR_LT  = 3'd4;
   localparam logic [2:0] BR_GE  = 3'd5;
   localparam logic [2:0] BR_LTU = 3'd6;
   localparam logic [2:0] BR_GEU = 3'd7;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ILLEGAL = 2'd1;
   localparam logic [1:0] ST_ODD_PC  = 2'd2;
   localparam logic [1:0] ST_RANGE   = 2'd3;

   typedef struct packed {
      logic [4:0]  op;
      logic [2:0]  cond;
      logic        comp;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [31:0] imm;
      logic [31:0] pdata;
   } dec_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        was_compressed;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        store_done;
      logic [31:0] store_addr;
      logic [31:0] store_data;
      logic        io_access;
      logic [1:0]  status;
   } res_type;

endpackage
`default_nettype wire

>>> design/rvx_if.sv
// Request and response channel interfaces of the execute core.
`default_nettype none
interface rvx_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [31:0] instr;
   logic [13:0] preload_addr;
   logic [31:0] preload_data;
   modport source (output valid, func, instr, preload_addr, preload_data, input ready);
   modport sink (input valid, func, instr, preload_addr, preload_data, output ready);
endinterface

interface rvx_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_pc;
   logic        was_compressed;
   logic        reg_written;
   logic [4:0]  reg_index;
   logic [31:0] reg_value;
   logic        store_done;
   logic [31:0] store_addr;
   logic [31:0] store_data;
   logic        io_access;
   logic [1:0]  status;
   modport source (output valid, next_pc, was_compressed, reg_written, reg_index, reg_value,
                   store_done, store_addr, store_data, io_access, status, input ready);
   modport sink (input valid, next_pc, was_compressed, reg_written, reg_index, reg_value,
                 store_done, store_addr, store_data, io_access, status, output ready);
endinterface
`default_nettype wire

>>> design/rv32ic_subset_execute_core.sv
// Top level of the RV32I and compressed subset execute core.
// The back end takes one item at a time from the queue and pops the next only after emitting
// a response; each item passes through the register file read, then execute and write-back;
// loads add the registered data memory read. An untaken response stalls the back end.
// Reset (synchronous, active high) clears the pc, halt state, register valid bits and queue;
// data memory contents are not cleared.
`default_nettype none
module rv32ic_subset_execute_core #(
   parameter int MEM_WORDS = 16384
) (
   input  wire logic clock,
   input  wire logic reset,
   rvx_req_if.sink   req,
   rvx_rsp_if.source rsp
);
   import rvx_pkg::*;

   logic    q_full, q_empty, q_push, q_pop;
   dec_type q_dec, q_head;

   rvx_front u_front (
      .req(req), .q_full(q_full), .q_push(q_push), .q_dec(q_dec));

   rvx_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_dec(q_dec),
      .full(q_full), .empty(q_empty), .pop(q_pop), .head(q_head));

   rvx_back #(.MEM_WORDS(MEM_WORDS)) u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_head(q_head),
      .q_pop(q_pop), .rsp(rsp));
endmodule
`default_nettype wire

>>> design/rvx_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rvx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

>>> design/rvx_front.sv
// Front end: accepts request transfers and decodes them into uniform operations.
`default_nettype none
module rvx_front (
   rvx_req_if.sink            req,
   input  wire logic          q_full,
   output logic               q_push,
   output rvx_pkg::dec_type   q_dec
);
   import rvx_pkg::*;

   logic [15:0] c;
   logic [31:0] i;
   logic [4:0]  rdf, rs2f, rdp, rs2p;
   logic [31:0] imm6;

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   assign c    = req.instr[15:0];
   assign i    = req.instr;
   assign rdf  = c[11:7];
   assign rs2f = c[6:2];
   assign rdp  = {2'b01, c[9:7]};
   assign rs2p = {2'b01, c[4:2]};
   assign imm6 = {{26{c[12]}}, c[12], c[6:2]};

   always_comb begin
      q_dec       = '0;
      q_dec.op    = OP_ILLEGAL;
      q_dec.pdata = req.preload_data;
      if (req.func) begin
         q_dec.op  = OP_PRELOAD;
         q_dec.imm = {18'b0, req.preload_addr};
      end else if (c[1:0] != 2'b11) begin
         q_dec.comp = 1'b1;
         unique case (c[1:0])
            2'b01: begin
               unique case (c[15:13]) inside
                  3'd0: begin
                     q_dec.op = OP_ADDI; q_dec.rd = rdf; q_dec.rs1 = rdf; q_dec.imm = imm6;
                  end
                  3'd1, 3'd5: begin
                     q_dec.op  = OP_JAL;
                     q_dec.rd  = (c[15:13] == 3'd1) ? 5'd1 : 5'd0;
                     q_dec.imm = {{20{c[12]}}, c[12], c[8], c[10:9], c[6], c[7], c[2], c[11],
                                  c[5:3], 1'b0};
                  end
                  3'd2: begin
                     q_dec.op = OP_ADDI; q_dec.rd = rdf; q_dec.imm = imm6;
                  end
                  3'd3: begin
                     if (rdf == 5'd0 || rdf == 5'd2) begin
                        q_dec.op  = OP_ADDI; q_dec.rd = 5'd2; q_dec.rs1 = 5'd2;
                        q_dec.imm = {{22{c[12]}}, c[12], c[4:3], c[5], c[2], c[6], 4'b0};
                     end else begin
                        q_dec.op  = OP_LUI; q_dec.rd = rdf;
                        q_dec.imm = {{14{c[12]}}, c[12], c[6:2], 12'b0};
                     end
                  end
                  3'd4: begin
                     if (c[11:10] == 2'b10) begin
                        q_dec.op = OP_ANDI; q_dec.rd = rdp; q_dec.rs1 = rdp; q_dec.imm = imm6;
                     end
                  end
                  default: begin
                     // Compare against x0 through the ordinary branch path.
                     q_dec.op   = OP_BR;
                     q_dec.cond = (c[13]) ? BR_NE : BR_EQ;
                     q_dec.rs1  = rdp;
                     q_dec.imm  = {{23{c[12]}}, c[12], c[6:5], c[2], c[11:10], c[4:3], 1'b0};
                  end
               endcase
            end
            2'b00: begin
               unique case (c[15:13])
                  3'd0: begin
                     q_dec.op  = OP_ADDI; q_dec.rd = rs2p; q_dec.rs1 = 5'd2;
                     q_dec.imm = {22'b0, c[10:7], c[12:11], c[5], c[6], 2'b0};
                  end
                  3'd2: begin
                     q_dec.op  = OP_LW; q_dec.rd = rs2p; q_dec.rs1 = rdp;
                     q_dec.imm = {25'b0, c[5], c[12:10], c[6], 2'b0};
                  end
                  3'd6: begin
                     q_dec.op  = OP_SW; q_dec.rs1 = rdp; q_dec.rs2 = rs2p;
                     q_dec.imm = {25'b0, c[5], c[12:10], c[6], 2'b0};
                  end
                  default: q_dec.op = OP_ILLEGAL;
               endcase
            end
            default: begin
               if (c[15:12] == 4'd8) begin
                  if (rdf != 5'd0 && rs2f != 5'd0) begin
                     q_dec.op = OP_ADD; q_dec.rd = rdf; q_dec.rs2 = rs2f;
                  end else if (rs2f == 5'd0) begin
                     q_dec.op = OP_JR; q_dec.rs1 = rdf;
                  end
               end else if (c[15:12] == 4'd9) begin
                  if (rdf != 5'd0 && rs2f != 5'd0) begin
                     q_dec.op = OP_ADD; q_dec.rd = rdf; q_dec.rs1 = rdf; q_dec.rs2 = rs2f;
                  end
               end else if (c[15:13] == 3'd6) begin
                  q_dec.op  = OP_SW; q_dec.rs1 = 5'd2; q_dec.rs2 = rs2f;
                  q_dec.imm = {24'b0, c[8:7], c[12:9], 2'b0};
               end
            end
         endcase
      end else begin
         q_dec.rd   = i[11:7];
         q_dec.rs1  = i[19:15];
         q_dec.rs2  = i[24:20];
         q_dec.cond = i[14:12];
         q_dec.imm  = {{20{i[31]}}, i[31:20]};
         unique case (i[6:0])
            OPC_LUI: begin
               q_dec.op = OP_LUI; q_dec.imm = i & UPPER_MASK;
            end
            OPC_AUIPC: begin
               q_dec.op = OP_AUIPC; q_dec.imm = i & UPPER_MASK;
            end
            OPC_OPIMM: begin
               if (i[14:12] == 3'd0) q_dec.op = OP_ADDI;
               else if (i[14:12] == 3'd7) q_dec.op = OP_ANDI;
            end
            OPC_OP: begin
               if (i[14:12] == 3'd4 && i[31:25] == 7'h00) q_dec.op = OP_XOR;
               else if (i[14:12] == 3'd0 && i[31:25] == 7'h00) q_dec.op = OP_ADD;
               else if (i[14:12] == 3'd0 && i[31:25] == 7'h20) q_dec.op = OP_SUB;
            end
            OPC_LOAD: begin
               if (i[14:12] == 3'd2) q_dec.op = OP_LW;
               else if (i[14:12] == 3'd4) q_dec.op = OP_LBU;
            end
            OPC_STORE: begin
               q_dec.rd  = 5'd0;
               q_dec.imm = {{20{i[31]}}, i[31:25], i[11:7]};
               if (i[14:12] == 3'd2) q_dec.op = OP_SW;
            end
            OPC_BRANCH: begin
               q_dec.rd  = 5'd0;
               q_dec.imm = {{19{i[31]}}, i[31], i[7], i[30:25], i[11:8], 1'b0};
               if (i[14:12] != 3'd0 && i[14:12] != 3'd2 && i[14:12] != 3'd3) q_dec.op = OP_BR;
            end
            OPC_JAL: begin
               q_dec.op  = OP_JAL;
               q_dec.imm = {{11{i[31]}}, i[31], i[19:12], i[20], i[30:21], 1'b0};
            end
            default: q_dec.op = OP_ILLEGAL;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> design/rvx_queue.sv
// Two-entry queue of decoded operations between the front end and the back end.
`default_nettype none
module rvx_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire rvx_pkg::dec_type push_dec,
   output logic                  full,
   output logic                  empty,
   input  wire logic             pop,
   output rvx_pkg::dec_type      head
);
   import rvx_pkg::*;

   localparam int PW = $clog2(QDEPTH);

   dec_type         entry_ff [QDEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]     count_ff;
   logic            do_push, do_pop;

   assign full    = (count_ff == (PW + 1)'(QDEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_dec;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end
endmodule
`default_nettype wire

>>> design/rvx_back.sv
// Back end: register file, data memory, execution sequencer and result register.
`default_nettype none
module rvx_back #(
   parameter int MEM_WORDS = 16384
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   input  wire rvx_pkg::dec_type q_head,
   output logic                  q_pop,
   rvx_rsp_if.source             rsp
);
   import rvx_pkg::*;

   localparam int AW = $clog2(MEM_WORDS);
   localparam logic [31:0] MEM_LIMIT = 32'(MEM_WORDS);
   localparam logic [31:0] STORE_MAX = 32'(MEM_WORDS * 4 - 4);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_LOAD = 2'd2;

   logic [1:0]  state_ff, state_in;
   dec_type     item_ff;
   logic [31:0] pc_ff, pc_in;
   logic        halted_ff, halted_in;
   logic [1:0]  cause_ff, cause_in;
   logic [31:0] rvalid_ff;
   logic [1:0]  ld_addr_ff;
   logic        ld_io_ff, ld_inr_ff;
   res_type     res_ff, res_in;
   logic        rsp_valid_ff;

   logic        out_free, emit, ld_start;
   logic        wr_en;
   logic [4:0]  wr_idx;
   logic [31:0] wr_val;
   logic [31:0] rf_a, rf_b, a, b, seq_pc, ea, word, ld_val;
   logic        dm_we, dm_re;
   logic [AW-1:0] dm_waddr, dm_raddr;
   logic [31:0] dm_wdata, dm_rdata;
   logic        take;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign q_pop     = (state_ff == S_IDLE) && !q_empty;

   rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock(clock), .we(wr_en), .waddr(wr_idx), .wdata(wr_val),
      .re(q_pop), .raddr(q_head.rs1), .rdata(rf_a));

   rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock(clock), .we(wr_en), .waddr(wr_idx), .wdata(wr_val),
      .re(q_pop), .raddr(q_head.rs2), .rdata(rf_b));

   rvx_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
      .clock(clock), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
      .re(dm_re), .raddr(dm_raddr), .rdata(dm_rdata));

   // Registers never written since reset read as zero; x0 is never marked valid.
   assign a      = (rvalid_ff[item_ff.rs1]) ? rf_a : 32'd0;
   assign b      = (rvalid_ff[item_ff.rs2]) ? rf_b : 32'd0;
   assign seq_pc = pc_ff + (item_ff.comp ? 32'd2 : 32'd4);
   assign ea     = a + item_ff.imm;
   assign word   = (ld_io_ff || !ld_inr_ff) ? 32'd0 : dm_rdata;

   always_comb begin
      case (ld_addr_ff)
         2'd0:    ld_val = {24'b0, word[7:0]};
         2'd1:    ld_val = {24'b0, word[15:8]};
         2'd2:    ld_val = {24'b0, word[23:16]};
         default: ld_val = {24'b0, word[31:24]};
      endcase
      if (item_ff.op == OP_LW) ld_val = word;
   end

   always_comb begin
      case (item_ff.cond)
         BR_EQ:   take = (a == b);
         BR_NE:   take = (a != b);
         BR_LT:   take = ($signed(a) < $signed(b));
         BR_GE:   take = ($signed(a) >= $signed(b));
         BR_LTU:  take = (a < b);
         default: take = (a >= b);
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      halted_in = halted_ff;
      cause_in  = cause_ff;
      res_in    = '0;
      res_in.next_pc = pc_ff;
      res_in.status  = cause_ff;
      emit      = 1'b0;
      ld_start  = 1'b0;
      wr_en     = 1'b0;
      wr_idx    = item_ff.rd;
      wr_val    = 32'd0;
      dm_we     = 1'b0;
      dm_waddr  = item_ff.imm[AW-1:0];
      dm_wdata  = item_ff.pdata;
      dm_re     = 1'b0;
      dm_raddr  = ea[AW+1:2];

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (item_ff.op == OP_PRELOAD) begin
                  dm_we = (item_ff.imm < MEM_LIMIT);
               end else if (halted_ff) begin
                  res_in.status = cause_ff;
               end else if (pc_ff[0]) begin
                  halted_in     = 1'b1;
                  cause_in      = ST_ODD_PC;
                  res_in.status = ST_ODD_PC;
               end else begin
                  res_in.was_compressed = item_ff.comp;
                  res_in.status         = ST_OK;
                  pc_in                 = seq_pc;
                  case (item_ff.op) inside
                     OP_LUI:   begin wr_en = 1'b1; wr_val = item_ff.imm; end
                     OP_AUIPC: begin wr_en = 1'b1; wr_val = pc_ff + item_ff.imm; end
                     OP_ADDI:  begin wr_en = 1'b1; wr_val = ea; end
                     OP_ANDI:  begin wr_en = 1'b1; wr_val = a & item_ff.imm; end
                     OP_XOR:   begin wr_en = 1'b1; wr_val = a ^ b; end
                     OP_ADD:   begin wr_en = 1'b1; wr_val = a + b; end
                     OP_SUB:   begin wr_en = 1'b1; wr_val = a - b; end
                     OP_LW, OP_LBU: begin
                        emit     = 1'b0;
                        ld_start = 1'b1;
                        dm_re    = 1'b1;
                        state_in = S_LOAD;
                     end
                     OP_SW: begin
                        if ((ea & IO_MASK) != 32'd0) begin
                           res_in.io_access = 1'b1;
                        end else if (ea > STORE_MAX) begin
                           halted_in     = 1'b1;
                           cause_in      = ST_RANGE;
                           res_in.status = ST_RANGE;
                           pc_in         = pc_ff;
                        end else begin
                           dm_we             = 1'b1;
                           dm_waddr          = ea[AW+1:2];
                           dm_wdata          = b;
                           res_in.store_done = 1'b1;
                           res_in.store_addr = ea & WORD_MASK;
                           res_in.store_data = b;
                        end
                     end
                     OP_BR: begin
                        if (take) pc_in = pc_ff + item_ff.imm;
                     end
                     OP_JAL: begin
                        wr_en  = 1'b1;
                        wr_val = seq_pc;
                        pc_in  = pc_ff + item_ff.imm;
                     end
                     OP_JR: begin
                        pc_in = a;
                     end
                     default: begin
                        halted_in     = 1'b1;
                        cause_in      = ST_ILLEGAL;
                        res_in.status = ST_ILLEGAL;
                        pc_in         = pc_ff;
                     end
                  endcase
                  res_in.next_pc = pc_in;
               end
            end
         end
         S_LOAD: begin
            if (out_free) begin
               emit                  = 1'b1;
               state_in              = S_IDLE;
               res_in.was_compressed = item_ff.comp;
               res_in.io_access      = ld_io_ff;
               res_in.status         = ST_OK;
               wr_en                 = 1'b1;
               wr_val                = ld_val;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Writes to x0 are dropped and not reported.
      if (item_ff.rd == 5'd0) wr_en = 1'b0;
      if (wr_en) begin
         res_in.reg_written = 1'b1;
         res_in.reg_index   = wr_idx;
         res_in.reg_value   = wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) item_ff <= q_head;
      if (ld_start) begin
         ld_addr_ff <= ea[1:0];
         ld_io_ff   <= ((ea & IO_MASK) != 32'd0);
         ld_inr_ff  <= ({2'b00, ea[31:2]} < MEM_LIMIT);
      end
      if (emit) res_ff <= res_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= 32'd0;
         halted_ff    <= 1'b0;
         cause_ff     <= ST_OK;
         rvalid_ff    <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         halted_ff <= halted_in;
         cause_ff  <= cause_in;
         if (wr_en) rvalid_ff[wr_idx] <= 1'b1;
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.next_pc        = res_ff.next_pc;
   assign rsp.was_compressed = res_ff.was_compressed;
   assign rsp.reg_written    = res_ff.reg_written;
   assign rsp.reg_index      = res_ff.reg_index;
   assign rsp.reg_value      = res_ff.reg_value;
   assign rsp.store_done     = res_ff.store_done;
   assign rsp.store_addr     = res_ff.store_addr;
   assign rsp.store_data     = res_ff.store_data;
   assign rsp.io_access      = res_ff.io_access;
   assign rsp.status         = res_ff.status;
endmodule
`default_nettype wire
